// ===== design/sqe_pkg.sv =====
// Shared constants and interface structs for the string quicksort engine.
// No dependencies; imported by every module of the block.
package sqe_pkg;

  localparam int MAX_NAMES  = 64;
  localparam int NAME_BYTES = 128;

  localparam int IDX_W  = $clog2(MAX_NAMES);
  localparam int CNT_W  = $clog2(MAX_NAMES + 1);
  localparam int LEN_W  = $clog2(NAME_BYTES + 1);
  localparam int KW     = $clog2(NAME_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_NAMES * NAME_BYTES);

  // write side of the name store, driven by the loader
  typedef struct packed {
    logic              byte_we;
    logic [ADDR_W-1:0] byte_addr;
    logic [7:0]        byte_data;
    logic              len_we;
    logic [IDX_W-1:0]  len_slot;
    logic [LEN_W-1:0]  len_data;
  } name_wr_t;

  // read side: two slots compared at one character position
  typedef struct packed {
    logic [IDX_W-1:0] slot_a;
    logic [IDX_W-1:0] slot_b;
    logic [KW-1:0]    pos;
  } name_rd_t;

  // read data, registered in the cycle after the request
  typedef struct packed {
    logic [LEN_W-1:0] len_a;
    logic [LEN_W-1:0] len_b;
    logic [7:0]       byte_a;
    logic [7:0]       byte_b;
  } name_rdata_t;

endpackage

// ===== design/string_quicksort_engine_top.sv =====
// Top level of the string quicksort engine: byte loader plus sort sequencer.
// Depends on sqe_pkg, sqe_names and sqe_sorter.
//
// Usage:
//   Input items are taken on a rising edge with start high and busy low. Each
//   item is one character (char_byte) with end_of_name marking the last one of
//   a name; an item with end_of_list set carries no character and closes the
//   list. Loading takes one item per cycle, busy stays low throughout.
//   After end_of_list busy rises on the next cycle and stays high while the
//   Lomuto quicksort runs over the order array. Every compare walks both names
//   byte by byte through the dual-read name store; a sort initialises the order
//   array, then partitions with swaps, with n^2/2 compares in the worst case.
//   Results then leave one at a time: result_valid high for one cycle
//   with slot_index, last_index (on the final one) and overflow. The receiver
//   cannot stall; results must be taken as they appear. An empty list gives no
//   results and busy never rises. Reset clears the loader counters and
//   returns the sequencer to idle; the memories hold no reset value.
module string_quicksort_engine_top import sqe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [7:0]       char_byte,
  input  logic             end_of_name,
  input  logic             end_of_list,
  output logic             result_valid,
  output logic [IDX_W-1:0] slot_index,
  output logic             last_index,
  output logic             overflow
);

  logic [CNT_W-1:0] count;   // names stored
  logic [LEN_W-1:0] cpos;    // characters of the current name
  logic             ovf_seen;

  logic             accept;
  logic             slot_free;
  logic             store_ok;
  logic [LEN_W-1:0] cpos_after;
  logic             close_eol;
  logic             go;
  logic [CNT_W-1:0] go_count;

  name_wr_t    wr;
  name_rd_t    rd;
  name_rdata_t rdata;

  assign accept     = start && !busy;
  assign slot_free  = count < CNT_W'(MAX_NAMES);
  assign store_ok   = slot_free && (cpos < LEN_W'(NAME_BYTES));
  assign cpos_after = cpos + LEN_W'(store_ok);
  // a pending name with no end marker is closed by the end of the list
  assign close_eol  = (cpos != '0) && slot_free;
  assign go         = accept && end_of_list;
  assign go_count   = count + CNT_W'(close_eol);

  always_comb begin
    wr.byte_we   = accept && !end_of_list && store_ok;
    wr.byte_addr = ADDR_W'(ADDR_W'(count[IDX_W-1:0]) * ADDR_W'(NAME_BYTES)
                   + ADDR_W'(cpos));
    wr.byte_data = char_byte;
    wr.len_slot  = count[IDX_W-1:0];
    if (end_of_list) begin
      wr.len_we   = accept && close_eol;
      wr.len_data = cpos;
    end else begin
      wr.len_we   = accept && end_of_name && slot_free;
      wr.len_data = cpos_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cpos     <= '0;
      ovf_seen <= 1'b0;
    end else if (accept) begin
      if (end_of_list) begin
        count    <= '0;
        cpos     <= '0;
        ovf_seen <= 1'b0;
      end else begin
        if (!store_ok) begin
          ovf_seen <= 1'b1;
        end
        if (end_of_name) begin
          cpos <= '0;
          if (slot_free) begin
            count <= count + CNT_W'(1);
          end
        end else begin
          cpos <= cpos_after;
        end
      end
    end
  end

  sqe_names u_names (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  sqe_sorter u_sorter (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .go_count     (go_count),
    .go_ovf       (ovf_seen),
    .busy         (busy),
    .rd           (rd),
    .rdata        (rdata),
    .result_valid (result_valid),
    .slot_index   (slot_index),
    .last_index   (last_index),
    .overflow     (overflow)
  );

endmodule

// ===== design/sqe_names.sv =====
// Name store: character memory and per-slot length memory, two read ports each.
// Depends on sqe_pkg.
module sqe_names import sqe_pkg::*; (
  input  logic        clk,
  input  name_wr_t    wr,
  input  name_rd_t    rd,
  output name_rdata_t rdata
);

  logic [7:0]       store [MAX_NAMES*NAME_BYTES];
  logic [LEN_W-1:0] lens  [MAX_NAMES];

  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;

  assign addr_a = ADDR_W'(ADDR_W'(rd.slot_a) * ADDR_W'(NAME_BYTES) + ADDR_W'(rd.pos));
  assign addr_b = ADDR_W'(ADDR_W'(rd.slot_b) * ADDR_W'(NAME_BYTES) + ADDR_W'(rd.pos));

  always_ff @(posedge clk) begin
    if (wr.byte_we) begin
      store[wr.byte_addr] <= wr.byte_data;
    end
    if (wr.len_we) begin
      lens[wr.len_slot] <= wr.len_data;
    end
    rdata.byte_a <= store[addr_a];
    rdata.byte_b <= store[addr_b];
    rdata.len_a  <= lens[rd.slot_a];
    rdata.len_b  <= lens[rd.slot_b];
  end

endmodule

// ===== design/sqe_sorter.sv =====
// Sort sequencer: order array, range stack, Lomuto partition loop, byte compare
// and result emission. Depends on sqe_pkg; reads names through sqe_names.
module sqe_sorter import sqe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [CNT_W-1:0] go_count,
  input  logic             go_ovf,
  output logic             busy,
  output name_rd_t         rd,
  input  name_rdata_t      rdata,
  output logic             result_valid,
  output logic [IDX_W-1:0] slot_index,
  output logic             last_index,
  output logic             overflow
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_SEED, S_POP, S_POPW, S_PIVW, S_JRD, S_JW, S_CL, S_CLW,
    S_CB, S_CBW, S_SWR, S_SWW1, S_SWW2, S_FW1, S_FW2, S_PUSH1, S_PUSH2,
    S_EMR, S_EMO
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] sp;
  logic [IDX_W-1:0] lo, hi, ip, j;
  logic [IDX_W-1:0] a, pivot, x;
  logic [KW-1:0]    pos;
  logic             ovf;

  logic [IDX_W-1:0]   order [MAX_NAMES];
  logic [2*IDX_W-1:0] stack [MAX_NAMES];
  logic [IDX_W-1:0]   ord_q;
  logic [2*IDX_W-1:0] stk_q;

  logic               ord_we;
  logic [IDX_W-1:0]   ord_wa, ord_wd, ord_ra;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_wa, stk_ra;
  logic [2*IDX_W-1:0] stk_wd;

  logic [7:0] ca, cb;
  logic       push_lo, push_hi;
  logic [CNT_W-1:0] sp_m1;

  assign ca = ({1'b0, pos} < {1'b0, rdata.len_a}) ? rdata.byte_a : 8'd0;
  assign cb = ({1'b0, pos} < {1'b0, rdata.len_b}) ? rdata.byte_b : 8'd0;
  assign push_lo = ({1'b0, ip} > CNT_W'(lo) + CNT_W'(1)) && (sp < CNT_W'(MAX_NAMES));
  assign push_hi = (CNT_W'(hi) > CNT_W'(ip) + CNT_W'(1)) && (sp < CNT_W'(MAX_NAMES));
  assign sp_m1   = sp - CNT_W'(1);

  assign rd.slot_a = a;
  assign rd.slot_b = pivot;
  assign rd.pos    = pos;

  always_comb begin
    ord_we = 1'b0;
    ord_wa = '0;
    ord_wd = '0;
    ord_ra = '0;
    stk_we = 1'b0;
    stk_wa = sp[IDX_W-1:0];
    stk_wd = '0;
    stk_ra = sp_m1[IDX_W-1:0];
    unique case (state)
      S_INIT: begin
        ord_we = 1'b1;
        ord_wa = k[IDX_W-1:0];
        ord_wd = k[IDX_W-1:0];
      end
      S_SEED: begin
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = {IDX_W'(n - CNT_W'(1)), IDX_W'(0)};
      end
      S_POPW:  ord_ra = stk_q[2*IDX_W-1:IDX_W];
      S_JRD:   ord_ra = (j < hi) ? j : ip;
      S_SWR:   ord_ra = ip;
      S_SWW1: begin
        ord_we = 1'b1; ord_wa = ip; ord_wd = a;
      end
      S_SWW2: begin
        ord_we = 1'b1; ord_wa = j; ord_wd = x;
      end
      S_FW1: begin
        ord_we = 1'b1; ord_wa = ip; ord_wd = pivot;
      end
      S_FW2: begin
        ord_we = 1'b1; ord_wa = hi; ord_wd = x;
      end
      S_PUSH1: begin
        stk_we = push_lo;
        stk_wd = {IDX_W'(ip - IDX_W'(1)), lo};
      end
      S_PUSH2: begin
        stk_we = push_hi;
        stk_wd = {hi, IDX_W'(ip + IDX_W'(1))};
      end
      S_EMR:   ord_ra = k[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order[ord_wa] <= ord_wd;
    end
    ord_q <= order[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[stk_wa] <= stk_wd;
    end
    stk_q <= stack[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      sp    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go && go_count != '0) begin
            n     <= go_count;
            ovf   <= go_ovf;
            k     <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (k == n - CNT_W'(1)) begin
            k     <= '0;
            state <= (n < CNT_W'(2)) ? S_EMR : S_SEED;
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        S_SEED: begin
          sp    <= CNT_W'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (sp == '0) begin
            k     <= '0;
            state <= S_EMR;
          end else begin
            sp    <= sp_m1;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          lo <= stk_q[IDX_W-1:0];
          hi <= stk_q[2*IDX_W-1:IDX_W];
          ip <= stk_q[IDX_W-1:0];
          j  <= stk_q[IDX_W-1:0];
          if (stk_q[IDX_W-1:0] >= stk_q[2*IDX_W-1:IDX_W]
              || CNT_W'(stk_q[2*IDX_W-1:IDX_W]) >= n) begin
            state <= S_POP;
          end else begin
            state <= S_PIVW;
          end
        end
        S_PIVW: begin
          pivot <= ord_q;
          state <= S_JRD;
        end
        S_JRD:  state <= (j < hi) ? S_JW : S_FW1;
        S_JW: begin
          a     <= ord_q;
          state <= S_CL;
        end
        S_CL:   state <= S_CLW;
        S_CLW: begin
          pos   <= '0;
          state <= S_CB;
        end
        S_CB:   state <= S_CBW;
        S_CBW: begin
          if (ca != cb) begin
            if (ca < cb) begin
              state <= S_SWR;
            end else begin
              j     <= j + IDX_W'(1);
              state <= S_JRD;
            end
          end else if (ca == 8'd0) begin
            j     <= j + IDX_W'(1);
            state <= S_JRD;
          end else begin
            pos   <= pos + KW'(1);
            state <= S_CB;
          end
        end
        S_SWR:  state <= S_SWW1;
        S_SWW1: begin
          x     <= ord_q;
          state <= S_SWW2;
        end
        S_SWW2: begin
          ip    <= ip + IDX_W'(1);
          j     <= j + IDX_W'(1);
          state <= S_JRD;
        end
        S_FW1: begin
          x     <= ord_q;
          state <= S_FW2;
        end
        S_FW2:  state <= S_PUSH1;
        S_PUSH1: begin
          if (push_lo) begin
            sp <= sp + CNT_W'(1);
          end
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (push_hi) begin
            sp <= sp + CNT_W'(1);
          end
          state <= S_POP;
        end
        S_EMR:  state <= S_EMO;
        S_EMO: begin
          k     <= k + CNT_W'(1);
          state <= (k == n - CNT_W'(1)) ? S_IDLE : S_EMR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_EMO);
  assign slot_index   = ord_q;
  assign last_index   = (k == n - CNT_W'(1));
  assign overflow     = ovf;

`ifndef ASSERT_OFF
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= CNT_W'(MAX_NAMES))
    else $error("range stack pointer beyond depth");
  a_ip_le_j: assert property (@(posedge clk) disable iff (rst)
    state == S_JRD |-> ip <= j && j <= hi)
    else $error("partition indices out of order");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_index |=> !busy)
    else $error("sorter still busy after last index");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> state == S_IDLE)
    else $error("sort started while busy");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for string_quicksort_engine_top.
// Depends on sqe_pkg and the block RTL; streams names, predicts the sorted
// slot order with a Lomuto quicksort of its own and checks every result item.
`timescale 1ns / 1ps

module tb_top;
  import sqe_pkg::*;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [7:0]       char_byte;
  logic             end_of_name;
  logic             end_of_list;
  logic             result_valid;
  logic [IDX_W-1:0] slot_index;
  logic             last_index;
  logic             overflow;

  string_quicksort_engine_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .char_byte(char_byte), .end_of_name(end_of_name), .end_of_list(end_of_list),
    .result_valid(result_valid), .slot_index(slot_index),
    .last_index(last_index), .overflow(overflow)
  );

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             last;
    logic             ovf;
  } sorted_slot_t;

  // predictor copy of the block state
  logic [7:0]       names_mem [MAX_NAMES][NAME_BYTES];
  int unsigned      names_len [MAX_NAMES];
  logic [IDX_W-1:0] order_mem [MAX_NAMES];
  int unsigned      names_held;
  int unsigned      chars_held;
  bit               dropped_seen;

  sorted_slot_t sorted_q[$];
  int unsigned  mismatches;
  int unsigned  items_sent;
  bit           idle_on;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #50ms;
    $display("string_quicksort_engine_top: mismatch");
    $finish;
  end

  // strcmp ordering of two slots: 1 if slot a sorts strictly before slot b
  function automatic bit name_before(int unsigned a, int unsigned b);
    int unsigned ca, cb;
    for (int k = 0; k <= NAME_BYTES; k++) begin
      ca = (k < names_len[a] && k < NAME_BYTES) ? names_mem[a][k] : 0;
      cb = (k < names_len[b] && k < NAME_BYTES) ? names_mem[b][k] : 0;
      if (ca != cb) return ca < cb;
      if (ca == 0) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void swap_order(int x, int y);
    logic [IDX_W-1:0] t;
    t = order_mem[x];
    order_mem[x] = order_mem[y];
    order_mem[y] = t;
  endfunction

  // Lomuto quicksort with last-element pivot, pending ranges on a stack
  function automatic void sort_names(int n);
    int lo_q[$];
    int hi_q[$];
    int lo, hi, i, p;
    if (n < 2) return;
    lo_q.push_back(0);
    hi_q.push_back(n - 1);
    while (lo_q.size() > 0) begin
      lo = lo_q.pop_back();
      hi = hi_q.pop_back();
      if (lo >= hi) continue;
      i = lo - 1;
      for (int j = lo; j < hi; j++) begin
        if (name_before(order_mem[j], order_mem[hi])) begin
          i++;
          swap_order(i, j);
        end
      end
      swap_order(i + 1, hi);
      p = i + 1;
      if (p - 1 > lo && lo_q.size() < MAX_NAMES) begin
        lo_q.push_back(lo);
        hi_q.push_back(p - 1);
      end
      if (hi > p + 1 && lo_q.size() < MAX_NAMES) begin
        lo_q.push_back(p + 1);
        hi_q.push_back(hi);
      end
    end
  endfunction

  function automatic void close_name();
    if (names_held < MAX_NAMES) begin
      names_len[names_held] = chars_held;
      names_held++;
    end
    chars_held = 0;
  endfunction

  // update the model for one accepted item, queue any sorted run it causes
  function automatic void predict_item(logic [7:0] ch, logic eon, logic eol);
    sorted_slot_t r;
    if (!eol) begin
      if (names_held >= MAX_NAMES) dropped_seen = 1'b1;
      else if (chars_held < NAME_BYTES) begin
        names_mem[names_held][chars_held] = ch;
        chars_held++;
      end else dropped_seen = 1'b1;
      if (eon) close_name();
      return;
    end
    if (chars_held > 0) close_name();
    for (int k = 0; k < names_held; k++) order_mem[k] = k[IDX_W-1:0];
    sort_names(names_held);
    for (int k = 0; k < names_held; k++) begin
      r.slot = order_mem[k];
      r.last = (k == names_held - 1);
      r.ovf  = dropped_seen;
      sorted_q.push_back(r);
    end
    names_held   = 0;
    chars_held   = 0;
    dropped_seen = 1'b0;
  endfunction

  // results cannot be held off; check each one on the edge that ends it
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result slot=%0d", slot_index);
      end else begin
        sorted_slot_t e;
        e = sorted_q.pop_front();
        if (slot_index !== e.slot || last_index !== e.last || overflow !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result: exp slot=%0d last=%0b ovf=%0b got slot=%0d last=%0b ovf=%0b",
                     e.slot, e.last, e.ovf, slot_index, last_index, overflow);
        end
      end
    end
  end

  // drive one item and hold it until taken; start stays high on return unless idle_on drops it
  task automatic send_item(logic [7:0] ch, logic eon, logic eol);
    start       <= 1'b1;
    char_byte   <= ch;
    end_of_name <= eon;
    end_of_list <= eol;
    do @(posedge clk); while (busy);
    predict_item(ch, eon, eol);
    items_sent++;
    if (idle_on && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_name(int len, bit wide, bit close);
    for (int k = 0; k < len; k++)
      send_item(wide ? 8'($urandom_range(255)) : 8'($urandom_range(99, 97)),
                close && (k == len - 1), 1'b0);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_item(s[k], k == s.len() - 1, 1'b0);
  endtask

  task automatic end_list();
    send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // extremes, ties, prefixes, zero byte, empty and single lists
  task automatic test_directed();
    send_text("b"); send_text("ab"); send_text("a"); send_text("ab");
    send_item(8'hFF, 1'b0, 1'b0); send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0); send_item(8'h41, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h61, 1'b0, 1'b0);           // unfinished, closed by end of list
    end_list();
    end_list();                             // empty list
    send_text("x");
    end_list();
  endtask

  // name longer than a slot, then more names than slots
  task automatic test_overflow();
    send_name(NAME_BYTES + 3, 1'b0, 1'b1);
    send_text("aa");
    end_list();
    for (int k = 0; k < MAX_NAMES + 2; k++) send_name(1, 1'b0, 1'b1);
    end_list();
  endtask

  task automatic test_random();
    int target;
    target = items_sent + 260;
    while (items_sent < target) begin
      idle_on = !(items_sent > target - 200 && items_sent < target - 80);
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(9) == 0) send_name($urandom_range(1, 12), 1'b1, 1'b1);
        else send_name($urandom_range(1, 4), 1'b0, 1'b1);
      end
      if ($urandom_range(3) == 0) send_name($urandom_range(1, 3), 1'b1, 1'b0);
      end_list();
    end
    idle_on = 1'b1;
  endtask

  // sender holds off until the previous run has fully drained
  task automatic test_pause();
    send_text("q"); send_text("p");
    end_list();
    wait_drained();
    send_text("p"); send_text("q");
    end_list();
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; char_byte = '0; end_of_name = 1'b0; end_of_list = 1'b0;
    mismatches = 0; items_sent = 0; idle_on = 1'b1;
    names_held = 0; chars_held = 0; dropped_seen = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_pause();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("string_quicksort_engine_top: match");
    else $display("string_quicksort_engine_top: mismatch");
    $finish;
  end

endmodule
